[rtl/core/cmic_pkg.sv]
// Shared constants and types for the inverse color mixing core.
package cmic_pkg;

    localparam int CoefFracBits = 12;
    localparam int ChanW  = 8;
    localparam int CoefW  = 16;
    localparam int AdjW   = 33;              // 2x 32-bit products, one subtract
    localparam int DetW   = 50;              // 3 x (16 x 33) summed
    localparam int NumW   = 44;              // 3 x (33 x 9) summed
    localparam int SNumW  = NumW + CoefFracBits;
    localparam int QW     = 9;               // quotient bits kept, 0..511 range
    localparam int RemW   = DetW + 1;

    typedef logic [ChanW-1:0] t_chan;
    typedef logic signed [CoefW-1:0] t_coef;

    typedef struct packed {
        t_chan cam_red;
        t_chan cam_green;
        t_chan cam_blue;
        t_coef m00;
        t_coef m01;
        t_coef m02;
        t_coef m10;
        t_coef m11;
        t_coef m12;
        t_coef m20;
        t_coef m21;
        t_coef m22;
    } t_in_item;

    typedef struct packed {
        t_chan prj_red;
        t_chan prj_green;
        t_chan prj_blue;
        logic  singular;
    } t_out_item;

endpackage

[rtl/core/cmic_if.sv]
// Valid/ready channel interfaces for the inverse color mixing core.
interface cmic_in_if import cmic_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface cmic_out_if import cmic_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/core/color_mixing_inverse_compensation_core.sv]
// Top level: pipelined 3x3 inverse color mixing with restoring quotient stages.
// Input data passes the four front stages, the QW divider stages and the output register.
// Throughput: one pixel per clock; the whole pipeline advances when the
// output register is empty or being taken, so a stall holds every stage.
// The quotient is built one bit per stage over QW stages after a sign fixup.
// Reset clears the valid bits only; payload registers are not reset.
module color_mixing_inverse_compensation_core import cmic_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    cmic_in_if.sink      i_pix,
    cmic_out_if.source   o_prj
);

    localparam int NS = QW;   // divider stages

    logic adv;
    logic r_v1, r_v2, r_v3, r_v4;
    logic [NS-1:0] r_vd;
    logic r_vo;

    assign adv = !r_vo || o_prj.ready;
    assign i_pix.ready = adv;

    // Stage 1: capture and cofactor products
    t_in_item r_in1;
    logic signed [31:0] r_p [0:17];
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_in1   <= i_pix.data;
            r_p[0]  <= i_pix.data.m11 * i_pix.data.m22;
            r_p[1]  <= i_pix.data.m12 * i_pix.data.m21;
            r_p[2]  <= i_pix.data.m02 * i_pix.data.m21;
            r_p[3]  <= i_pix.data.m01 * i_pix.data.m22;
            r_p[4]  <= i_pix.data.m01 * i_pix.data.m12;
            r_p[5]  <= i_pix.data.m02 * i_pix.data.m11;
            r_p[6]  <= i_pix.data.m12 * i_pix.data.m20;
            r_p[7]  <= i_pix.data.m10 * i_pix.data.m22;
            r_p[8]  <= i_pix.data.m00 * i_pix.data.m22;
            r_p[9]  <= i_pix.data.m02 * i_pix.data.m20;
            r_p[10] <= i_pix.data.m02 * i_pix.data.m10;
            r_p[11] <= i_pix.data.m00 * i_pix.data.m12;
            r_p[12] <= i_pix.data.m10 * i_pix.data.m21;
            r_p[13] <= i_pix.data.m11 * i_pix.data.m20;
            r_p[14] <= i_pix.data.m01 * i_pix.data.m20;
            r_p[15] <= i_pix.data.m00 * i_pix.data.m21;
            r_p[16] <= i_pix.data.m00 * i_pix.data.m11;
            r_p[17] <= i_pix.data.m01 * i_pix.data.m10;
        end
    end

    // Stage 2: adjugate
    logic signed [AdjW-1:0] r_a [0:8];
    t_in_item r_in2;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_in2 <= r_in1;
            for (int k = 0; k < 9; k++) begin
                r_a[k] <= AdjW'(r_p[2*k]) - AdjW'(r_p[2*k+1]);
            end
        end
    end

    // Stage 3: products for determinant and numerators
    logic signed [48:0] r_dp [0:2];
    logic signed [41:0] r_np [0:8];
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_dp[0] <= r_in2.m00 * r_a[0];
            r_dp[1] <= r_in2.m01 * r_a[3];
            r_dp[2] <= r_in2.m02 * r_a[6];
            for (int i = 0; i < 3; i++) begin
                r_np[3*i]   <= r_a[3*i]   * $signed({1'b0, r_in2.cam_red});
                r_np[3*i+1] <= r_a[3*i+1] * $signed({1'b0, r_in2.cam_green});
                r_np[3*i+2] <= r_a[3*i+2] * $signed({1'b0, r_in2.cam_blue});
            end
        end
    end

    // Stage 4: sums, then normalize sign so the divisor is positive
    logic signed [DetW-1:0] n_det;
    logic signed [NumW-1:0] n_num [0:2];
    logic [RemW-1:0] r_den;
    logic [SNumW:0]  r_mag [0:2];   // |num| * 2^frac
    logic [2:0]      r_neg;
    logic            r_sing4;
    always_comb begin
        n_det = DetW'(r_dp[0]) + DetW'(r_dp[1]) + DetW'(r_dp[2]);
        for (int i = 0; i < 3; i++) begin
            n_num[i] = NumW'(r_np[3*i]) + NumW'(r_np[3*i+1]) + NumW'(r_np[3*i+2]);
        end
    end
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_sing4 <= (n_det == '0);
            r_den   <= n_det[DetW-1] ? RemW'(-n_det) : RemW'(n_det);
            for (int i = 0; i < 3; i++) begin
                r_neg[i] <= n_num[i][NumW-1] ^ n_det[DetW-1];
                r_mag[i] <= {(n_num[i][NumW-1] ? (SNumW-CoefFracBits+1)'(-n_num[i])
                                               : (SNumW-CoefFracBits+1)'(n_num[i])),
                             {CoefFracBits{1'b0}}};
            end
        end
    end

    // Divider stages: quotient bits QW-1..0 of mag/den; high overflow -> sat.
    // The partial remainder starts as mag >> QW, which is below den unless the
    // quotient needs more than QW bits; then the overflow flag saturates.
    logic [RemW-1:0] r_rem [0:NS-1][0:2];
    logic [QW-1:0]   r_dm  [0:NS-2][0:2];   // dividend bits still to shift in
    logic [QW-1:0]   r_q   [0:NS-1][0:2];
    logic [2:0]      r_ovf [0:NS-1];
    logic [2:0]      r_dneg[0:NS-1];
    logic [RemW-1:0] r_dd  [0:NS-1];
    logic            r_ds  [0:NS-1];

    // One restoring step: {quotient bit, next remainder}
    function automatic logic [RemW:0] div_step(input logic [RemW-1:0] rem,
                                               input logic            bit_in,
                                               input logic [RemW-1:0] dsr);
        logic [RemW:0] trial;
        trial = {rem, bit_in};
        if (trial >= {1'b0, dsr}) begin
            return {1'b1, RemW'(trial - {1'b0, dsr})};
        end
        return {1'b0, RemW'(trial)};
    endfunction

    // overflow: mag >= den << QW
    logic [2:0]    n_ovf0;
    logic [RemW:0] n_st [0:NS-1][0:2];
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_ovf0[i]  = (r_mag[i] >> QW) >= (SNumW+1)'(r_den);
            n_st[0][i] = div_step(RemW'(r_mag[i] >> QW), r_mag[i][QW-1], r_den);
            for (int s = 1; s < NS; s++) begin
                n_st[s][i] = div_step(r_rem[s-1][i], r_dm[s-1][i][QW-1], r_dd[s-1]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                r_rem[0][i] <= n_st[0][i][RemW-1:0];
                r_q[0][i]   <= {{(QW-1){1'b0}}, n_st[0][i][RemW]};
                r_dm[0][i]  <= {r_mag[i][QW-2:0], 1'b0};
                for (int s = 1; s < NS; s++) begin
                    r_rem[s][i] <= n_st[s][i][RemW-1:0];
                    r_q[s][i]   <= {r_q[s-1][i][QW-2:0], n_st[s][i][RemW]};
                end
                for (int s = 1; s < NS - 1; s++) begin
                    r_dm[s][i] <= {r_dm[s-1][i][QW-2:0], 1'b0};
                end
            end
            r_ovf[0]  <= n_ovf0;
            r_dneg[0] <= r_neg;
            r_dd[0]   <= r_den;
            r_ds[0]   <= r_sing4;
            for (int s = 1; s < NS; s++) begin
                r_ovf[s]  <= r_ovf[s-1];
                r_dneg[s] <= r_dneg[s-1];
                r_dd[s]   <= r_dd[s-1];
                r_ds[s]   <= r_ds[s-1];
            end
        end
    end

    // Output: round half even, saturate; negative results and singular pixels give 0
    t_out_item r_out;
    t_out_item n_out;
    always_comb begin
        logic [RemW:0] twor;
        logic          up;
        logic [QW:0]   qr;
        logic [ChanW-1:0] ch [0:2];
        for (int i = 0; i < 3; i++) begin
            twor = {r_rem[NS-1][i], 1'b0};
            up   = (twor > (RemW+1)'(r_dd[NS-1]))
                || ((twor == (RemW+1)'(r_dd[NS-1])) && r_q[NS-1][i][0]);
            qr   = (QW+1)'(r_q[NS-1][i]) + (QW+1)'(up);
            if (r_dneg[NS-1][i] && (qr != '0)) begin
                ch[i] = '0;
            end else if (r_ovf[NS-1][i] || qr > (QW+1)'(255)) begin
                ch[i] = r_dneg[NS-1][i] ? '0 : 8'hFF;
            end else begin
                ch[i] = qr[ChanW-1:0];
            end
            if (r_ds[NS-1]) begin
                ch[i] = '0;
            end
        end
        n_out.prj_red   = ch[0];
        n_out.prj_green = ch[1];
        n_out.prj_blue  = ch[2];
        n_out.singular  = r_ds[NS-1];
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0; r_v2 <= 1'b0; r_v3 <= 1'b0; r_v4 <= 1'b0;
            r_vd <= '0;   r_vo <= 1'b0;
        end else if (adv) begin
            r_v1 <= i_pix.valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_vd <= {r_vd[NS-2:0], r_v4};
            r_vo <= r_vd[NS-1];
        end
    end

    assign o_prj.valid = r_vo;
    assign o_prj.data  = r_out;

endmodule

[tb/testbench.sv]
// Self-checking testbench for the inverse color mixing compensation core.
module testbench import cmic_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    class ProjectorScoreboard;
        t_out_item pending[$];
        int mismatches;
        int checked;
        int singular_seen;

        // Round num/den to nearest, ties to even, then clamp to 0..255.
        function automatic t_chan div_round_clamp(longint num, longint den);
            longint q;
            longint r;
            if (den < 0) begin
                den = -den;
                num = -num;
            end
            q = num / den;
            r = num - q * den;
            if (r < 0) begin
                q -= 1;
                r += den;
            end
            if (2 * r > den || (2 * r == den && q[0])) q += 1;
            if (q < 0) return 8'd0;
            if (q > 255) return 8'd255;
            return t_chan'(q);
        endfunction

        function void note_pixel(t_in_item px);
            longint m[3][3];
            longint a[3][3];
            longint c[3];
            longint det;
            longint num;
            t_out_item exp_item;
            c[0] = px.cam_red;
            c[1] = px.cam_green;
            c[2] = px.cam_blue;
            m[0][0] = px.m00; m[0][1] = px.m01; m[0][2] = px.m02;
            m[1][0] = px.m10; m[1][1] = px.m11; m[1][2] = px.m12;
            m[2][0] = px.m20; m[2][1] = px.m21; m[2][2] = px.m22;
            a[0][0] = m[1][1] * m[2][2] - m[1][2] * m[2][1];
            a[0][1] = m[0][2] * m[2][1] - m[0][1] * m[2][2];
            a[0][2] = m[0][1] * m[1][2] - m[0][2] * m[1][1];
            a[1][0] = m[1][2] * m[2][0] - m[1][0] * m[2][2];
            a[1][1] = m[0][0] * m[2][2] - m[0][2] * m[2][0];
            a[1][2] = m[0][2] * m[1][0] - m[0][0] * m[1][2];
            a[2][0] = m[1][0] * m[2][1] - m[1][1] * m[2][0];
            a[2][1] = m[0][1] * m[2][0] - m[0][0] * m[2][1];
            a[2][2] = m[0][0] * m[1][1] - m[0][1] * m[1][0];
            det = m[0][0] * a[0][0] + m[0][1] * a[1][0] + m[0][2] * a[2][0];
            exp_item = '0;
            if (det == 0) begin
                exp_item.singular = 1'b1;
            end else begin
                num = (a[0][0] * c[0] + a[0][1] * c[1] + a[0][2] * c[2]) <<< CoefFracBits;
                exp_item.prj_red = div_round_clamp(num, det);
                num = (a[1][0] * c[0] + a[1][1] * c[1] + a[1][2] * c[2]) <<< CoefFracBits;
                exp_item.prj_green = div_round_clamp(num, det);
                num = (a[2][0] * c[0] + a[2][1] * c[1] + a[2][2] * c[2]) <<< CoefFracBits;
                exp_item.prj_blue = div_round_clamp(num, det);
            end
            pending.push_back(exp_item);
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", got);
                return;
            end
            want = pending.pop_front();
            checked++;
            if (got.singular) singular_seen++;
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch #%0d: expected r=%0d g=%0d b=%0d s=%0d",
                             checked, want.prj_red, want.prj_green, want.prj_blue,
                             want.singular,
                             ", got r=%0d g=%0d b=%0d s=%0d",
                             got.prj_red, got.prj_green, got.prj_blue, got.singular);
            end
        endfunction
    endclass

    localparam int Latency = 14;
    localparam int NumRandom = 1730;
    localparam longint CycleLimit = 200000;
    localparam t_coef One = t_coef'(1 << CoefFracBits);
    localparam t_coef Two = t_coef'(2 << CoefFracBits);

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    longint cycle_count = 0;
    bit hold_off = 1'b0;

    cmic_in_if  pix_if();
    cmic_out_if prj_if();

    ProjectorScoreboard sb = new();

    color_mixing_inverse_compensation_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_if.sink),
        .o_prj   (prj_if.source)
    );

    always #2 i_clk = ~i_clk;

    initial begin
        pix_if.valid = 1'b0;
        pix_if.data = '0;
        prj_if.ready = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Score both sides at the rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n && pix_if.valid && pix_if.ready) sb.note_pixel(pix_if.data);
        if (i_rst_n && prj_if.valid && prj_if.ready) sb.check_result(prj_if.data);
    end

    // Receiver: random back-pressure per transaction, plus one long hold-off.
    initial begin : sink_proc
        int wait_cycles;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_off) begin
                prj_if.ready <= 1'b0;
            end else if (prj_if.ready && prj_if.valid) begin
                wait_cycles = $urandom_range(0, 4);
                if (wait_cycles != 0) begin
                    prj_if.ready <= 1'b0;
                    repeat (wait_cycles - 1) @(negedge i_clk);
                    prj_if.ready <= 1'b1;
                end
            end else begin
                prj_if.ready <= 1'b1;
            end
        end
    end

    // Hold valid across back-to-back transactions; drop it only for a gap.
    task automatic send_pixel(t_in_item px, int gap);
        if (gap != 0) begin
            pix_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        pix_if.data <= px;
        pix_if.valid <= 1'b1;
        @(posedge i_clk);
        while (!pix_if.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic t_in_item diag_pixel(t_coef d0, t_coef d1, t_coef d2,
                                           t_chan r, t_chan g, t_chan b);
        t_in_item px;
        px = '0;
        px.m00 = d0; px.m11 = d1; px.m22 = d2;
        px.cam_red = r; px.cam_green = g; px.cam_blue = b;
        return px;
    endfunction

    // Mostly well-conditioned matrices near identity, some fully random, some rank-deficient, some small-integer.
    function automatic t_in_item random_pixel();
        t_in_item px;
        px = t_in_item'({$urandom(), $urandom(), $urandom(),
                         $urandom(), $urandom(), $urandom()});
        px.cam_red = t_chan'($urandom_range(0, 255));
        px.cam_green = t_chan'($urandom_range(0, 255));
        px.cam_blue = t_chan'($urandom_range(0, 255));
        case ($urandom_range(0, 9))
            0, 1: begin
                px.m00 = t_coef'($urandom()); px.m01 = t_coef'($urandom());
                px.m02 = t_coef'($urandom()); px.m10 = t_coef'($urandom());
                px.m11 = t_coef'($urandom()); px.m12 = t_coef'($urandom());
                px.m20 = t_coef'($urandom()); px.m21 = t_coef'($urandom());
                px.m22 = t_coef'($urandom());
            end
            2: begin
                // rank-deficient: row 2 copies row 0
                px.m20 = px.m00; px.m21 = px.m01; px.m22 = px.m02;
            end
            3: begin
                px.m00 = t_coef'($signed($urandom_range(0, 15)) - 8);
                px.m01 = t_coef'($signed($urandom_range(0, 15)) - 8);
                px.m02 = t_coef'($signed($urandom_range(0, 15)) - 8);
                px.m10 = t_coef'($signed($urandom_range(0, 15)) - 8);
                px.m11 = t_coef'($signed($urandom_range(0, 15)) - 8);
                px.m12 = t_coef'($signed($urandom_range(0, 15)) - 8);
                px.m20 = t_coef'($signed($urandom_range(0, 15)) - 8);
                px.m21 = t_coef'($signed($urandom_range(0, 15)) - 8);
                px.m22 = t_coef'($signed($urandom_range(0, 15)) - 8);
            end
            default: begin
                px.m00 = t_coef'(One + $signed($urandom_range(0, 2047)) - 1024);
                px.m11 = t_coef'(One + $signed($urandom_range(0, 2047)) - 1024);
                px.m22 = t_coef'(One + $signed($urandom_range(0, 2047)) - 1024);
                px.m01 = t_coef'($signed($urandom_range(0, 1023)) - 512);
                px.m02 = t_coef'($signed($urandom_range(0, 1023)) - 512);
                px.m10 = t_coef'($signed($urandom_range(0, 1023)) - 512);
                px.m12 = t_coef'($signed($urandom_range(0, 1023)) - 512);
                px.m20 = t_coef'($signed($urandom_range(0, 1023)) - 512);
                px.m21 = t_coef'($signed($urandom_range(0, 1023)) - 512);
            end
        endcase
        return px;
    endfunction

    initial begin : stim_proc
        t_in_item px;
        int n;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: identity, extremes, saturation, ties, singular.
        send_pixel(diag_pixel(One, One, One, 8'd0, 8'd0, 8'd0), 0);
        send_pixel(diag_pixel(One, One, One, 8'd255, 8'd255, 8'd255), 0);
        send_pixel(diag_pixel(One, One, One, 8'd1, 8'd128, 8'd200), 0);
        send_pixel(diag_pixel(Two, Two, Two, 8'd3, 8'd5, 8'd1), 0);
        send_pixel(diag_pixel(Two, Two, Two, 8'd7, 8'd9, 8'd255), 0);
        send_pixel(diag_pixel(One >>> 1, One >>> 1, One >>> 1, 8'd200, 8'd1, 8'd128), 0);
        send_pixel(diag_pixel(-One, -One, -One, 8'd100, 8'd0, 8'd255), 0);
        send_pixel(diag_pixel(16'sh7fff, 16'sh7fff, 16'sh7fff, 8'd255, 8'd255, 8'd255), 0);
        send_pixel(diag_pixel(-16'sh8000, -16'sh8000, -16'sh8000, 8'd255, 8'd1, 8'd0), 0);
        send_pixel(diag_pixel(16'sd1, 16'sd1, 16'sd1, 8'd1, 8'd0, 8'd255), 0);
        send_pixel(diag_pixel(16'sd1, -16'sd1, 16'sd1, 8'd255, 8'd255, 8'd255), 0);
        send_pixel(diag_pixel(16'sd0, One, One, 8'd50, 8'd50, 8'd50), 0);
        px = '1;
        send_pixel(px, 0);
        px = '0;
        send_pixel(px, 0);
        px = diag_pixel(-16'sh8000, 16'sh7fff, -16'sh8000, 8'd255, 8'd255, 8'd255);
        px.m01 = 16'sh7fff; px.m12 = -16'sh8000; px.m20 = 16'sh7fff;
        send_pixel(px, 0);
        px = diag_pixel(One, One, One, 8'd10, 8'd20, 8'd30);
        px.m01 = -One; px.m10 = One >>> 2; px.m21 = -(One >>> 3);
        send_pixel(px, 0);

        for (n = 0; n < NumRandom; n++) begin
            if (n == 600) begin
                // Drain completely, then resume.
                pix_if.valid <= 1'b0;
                while (sb.pending.size() != 0) @(negedge i_clk);
            end
            if (n == 1000) begin
                fork
                    begin
                        hold_off = 1'b1;
                        repeat (60) @(negedge i_clk);
                        hold_off = 1'b0;
                    end
                join_none
            end
            send_pixel(random_pixel(), (n >= 1000 && n < 1080) ? 0 : $urandom_range(0, 4));
        end

        pix_if.valid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (Latency + 10) @(negedge i_clk);
        $display("checked %0d compensated pixels, %0d singular matrices",
                 sb.checked, sb.singular_seen);
        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("%0d mismatches", sb.mismatches);
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
